/* hw/rtl/sqd_pkg.sv */
// Shared types and codes of the shortest queue dispatcher.
`timescale 1ns / 1ps

package sqd_pkg;

   // Command codes carried on the request side tuser.
   localparam logic [1:0] CMD_SUBMIT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_STATS  = 2'd2;

   // Status codes carried on the response side tuser.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_CLOSED = 2'd3;

   localparam logic [1:0] KIND_CPU = 2'd0;
   localparam logic [1:0] KIND_IO  = 2'd1;

   localparam logic [4:0] MAX_PER_QUEUE_RESET = 5'd4;

   // One stored request: id, then cycle count, then kind.
   localparam int STORE_W = 49;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [3:0]  queue_select;
      logic [1:0]  request_kind;
      logic [15:0] cycle_count;
      logic [30:0] request_id;
   } req_data_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] top_io_cycles;
      logic [3:0]  top_io_queue;
      logic        io_found;
      logic [4:0]  top_cpu_count;
      logic [3:0]  top_cpu_queue;
      logic        cpu_found;
      logic [4:0]  queue_pending;
      logic [1:0]  out_request_kind;
      logic [15:0] out_cycle_count;
      logic [30:0] out_request_id;
      logic [3:0]  queue_index;
   } rsp_data_type;

   // Control from the sequencer to the compare unit.
   typedef struct packed {
      logic clear;
      logic issue;
   } scan_ctrl_type;

endpackage

/* hw/rtl/sqd_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module sqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sqd_scan.sv */
// Shared compare unit that keeps the running minimum and maxima of a queue scan.
`timescale 1ns / 1ps

module sqd_scan #(
   parameter int QIW = 4,
   parameter int CW  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sqd_pkg::scan_ctrl_type ctrl,
   input  logic [QIW-1:0]        issue_index,
   input  logic [CW-1:0]         entry_pend,
   input  logic [CW-1:0]         entry_cpu,
   input  logic [15:0]           entry_peak,
   output logic [QIW-1:0]        best_index,
   output logic [CW-1:0]         best_pend,
   output logic                  cpu_found,
   output logic [QIW-1:0]        cpu_index,
   output logic [CW-1:0]         cpu_max,
   output logic                  io_found,
   output logic [QIW-1:0]        io_index,
   output logic [15:0]           io_max
);

   import sqd_pkg::*;

   logic           take_ff;
   logic [QIW-1:0] take_index_ff;
   logic [QIW-1:0] best_index_ff, best_index_in;
   logic [CW-1:0]  best_pend_ff, best_pend_in;
   logic           cpu_found_ff, cpu_found_in;
   logic [QIW-1:0] cpu_index_ff, cpu_index_in;
   logic [CW-1:0]  cpu_max_ff, cpu_max_in;
   logic           io_found_ff, io_found_in;
   logic [QIW-1:0] io_index_ff, io_index_in;
   logic [15:0]    io_max_ff, io_max_in;

   // RAM data arrives in the cycle after its address was issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= ctrl.issue;
      end
      take_index_ff <= issue_index;
   end

   always_comb begin
      best_index_in = best_index_ff;
      best_pend_in  = best_pend_ff;
      cpu_found_in  = cpu_found_ff;
      cpu_index_in  = cpu_index_ff;
      cpu_max_in    = cpu_max_ff;
      io_found_in   = io_found_ff;
      io_index_in   = io_index_ff;
      io_max_in     = io_max_ff;
      if (ctrl.clear) begin
         best_index_in = '0;
         best_pend_in  = '0;
         cpu_found_in  = 1'b0;
         cpu_index_in  = '0;
         cpu_max_in    = '0;
         io_found_in   = 1'b0;
         io_index_in   = '0;
         io_max_in     = '0;
      end else if (take_ff) begin
         // The first queue seeds the minimum; later ones replace it only when strictly smaller.
         if (take_index_ff == '0 || entry_pend < best_pend_ff) begin
            best_index_in = take_index_ff;
            best_pend_in  = entry_pend;
         end
         if (entry_cpu > cpu_max_ff) begin
            cpu_found_in = 1'b1;
            cpu_index_in = take_index_ff;
            cpu_max_in   = entry_cpu;
         end
         if (entry_peak > io_max_ff) begin
            io_found_in = 1'b1;
            io_index_in = take_index_ff;
            io_max_in   = entry_peak;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_index_ff <= best_index_in;
      best_pend_ff  <= best_pend_in;
      cpu_found_ff  <= cpu_found_in;
      cpu_index_ff  <= cpu_index_in;
      cpu_max_ff    <= cpu_max_in;
      io_found_ff   <= io_found_in;
      io_index_ff   <= io_index_in;
      io_max_ff     <= io_max_in;
   end

   assign best_index = best_index_ff;
   assign best_pend  = best_pend_ff;
   assign cpu_found  = cpu_found_ff;
   assign cpu_index  = cpu_index_ff;
   assign cpu_max    = cpu_max_ff;
   assign io_found   = io_found_ff;
   assign io_index   = io_index_ff;
   assign io_max     = io_max_ff;

   // The cpu found flag goes with a nonzero cpu maximum after the compare unit is cleared.
   a_cpu_found: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.clear) |-> (cpu_found_ff == (cpu_max_ff != '0)))
      else $error("cpu found flag disagrees with cpu maximum");

endmodule

/* hw/rtl/shortest_queue_dispatcher_core.sv */
// Top level of the join shortest queue dispatcher: sequencer, queue state, request store and compare unit.
`timescale 1ns / 1ps

// The request channel (req_) carries one command per request: a submit that places a
// request in the open queue with the fewest pending entries (or opens the next queue when
// that one is at its cap), a remove that pops the head of a chosen queue, or a statistics
// query. The response channel (rsp_) returns exactly one response per request, with the
// outcome code on rsp_tuser. The csr_ port writes the per-queue cap; write it only while
// no request is in flight. Requests are handled one at a time. A submit scans the open
// queues, then decides and updates the chosen queue (no scan when no queue is open yet,
// no update when the request is dropped), a statistics query scans and reports, and a
// remove checks the queue, reads its counters, then reads and pops its head entry. Each
// open queue's counters are read one per cycle from the queue state RAM and fed through
// a single compare unit. The per-queue counters and the request store live in RAMs with
// one read and one write port; a remove needs two dependent reads. req_tready is high
// only while the sequencer is idle, so the next request can be taken in the cycle after
// the previous response is loaded. After reset no queue is open and the cap is 4; a queue
// starts from zero when it is opened, so no clearing pass is needed. When the receiver
// stalls, the response waits in the output register and the next request is still
// accepted and worked on; it is held in its final step until the output register is free.
module shortest_queue_dispatcher_core #(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: request_id, cycle_count, request_kind, queue_select, zero pad.
   input  sqd_pkg::req_data_type req_tdata,
   // Fields from bit 0: command.
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: queue_index, out_request_id, out_cycle_count, out_request_kind,
   // queue_pending, cpu_found, top_cpu_queue, top_cpu_count, io_found, top_io_queue,
   // top_io_cycles, zero pad.
   output sqd_pkg::rsp_data_type rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]           rsp_tuser,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data
);

   import sqd_pkg::*;

   localparam int QIW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int OW   = $clog2(NUM_QUEUES + 1);
   localparam int QDW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int SD   = NUM_QUEUES * QUEUE_DEPTH;
   localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
   localparam int QS_W = QDW + 3 * CW + 16;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN     = 4'd1;
   localparam logic [3:0] S_SCAN_END = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_SUB_UPD  = 4'd4;
   localparam logic [3:0] S_RM_CHECK = 4'd5;
   localparam logic [3:0] S_RM_HEAD  = 4'd6;
   localparam logic [3:0] S_RM_POP   = 4'd7;
   localparam logic [3:0] S_REPORT   = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0]     state_ff, state_in;
   logic [4:0]     max_ff, max_in;
   logic [OW-1:0]  open_ff, open_in;
   logic [QIW-1:0] cnt_ff, cnt_in;
   logic [QIW-1:0] target_ff, target_in;
   logic           new_ff, new_in;
   logic [1:0]     cmd_ff, cmd_in;
   req_data_type   req_ff, req_in;

   // Entry of the queue being popped, held between the two RAM reads of a remove.
   logic [QDW-1:0] head_ff, head_in;
   logic [CW-1:0]  pend_ff, pend_in;
   logic [CW-1:0]  cpu_ff, cpu_in;
   logic [CW-1:0]  io_ff, io_in;
   logic [15:0]    peak_ff, peak_in;

   logic [1:0]     res_status_ff, res_status_in;
   rsp_data_type   res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;

   // Queue state RAM port signals.
   logic            qs_rd_en;
   logic [QIW-1:0]  qs_rd_addr;
   logic [QS_W-1:0] qs_rd_data;
   logic            qs_wr_en;
   logic [QIW-1:0]  qs_wr_addr;
   logic [QS_W-1:0] qs_wr_data;
   logic [QDW-1:0]  qs_head;
   logic [CW-1:0]   qs_pend, qs_cpu, qs_io;
   logic [15:0]     qs_peak;

   // Request store RAM port signals.
   logic               st_rd_en;
   logic [SAW-1:0]     st_rd_addr;
   logic [STORE_W-1:0] st_rd_data;
   logic               st_wr_en;
   logic [SAW-1:0]     st_wr_addr;
   logic [STORE_W-1:0] st_wr_data;

   // Compare unit results.
   scan_ctrl_type  scan_ctrl;
   logic [QIW-1:0] best_index, cpu_index, io_index;
   logic [CW-1:0]  best_pend, cpu_max;
   logic           cpu_found, io_found;
   logic [15:0]    io_max;

   // Decision and update terms.
   logic           accept;
   logic [CW-1:0]  cap;
   logic           use_best;
   logic           can_open;
   logic [QIW-1:0] target;
   logic [QIW-1:0] sel_q;
   logic           sel_open;
   logic [QDW-1:0] e_head;
   logic [CW-1:0]  e_pend, e_cpu, e_io;
   logic [15:0]    e_peak;
   logic [CW-1:0]  sub_pend, sub_cpu, sub_io;
   logic [15:0]    sub_peak;
   logic [CW:0]    slot_sum;
   logic [CW:0]    slot_wrap;
   logic [1:0]     pop_kind;
   logic [QDW:0]   head_next;
   logic [QDW-1:0] pop_head;
   logic [CW-1:0]  pop_pend, pop_cpu, pop_io;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign qs_head = qs_rd_data[QDW-1:0];
   assign qs_pend = qs_rd_data[QDW +: CW];
   assign qs_cpu  = qs_rd_data[QDW + CW +: CW];
   assign qs_io   = qs_rd_data[QDW + 2 * CW +: CW];
   assign qs_peak = qs_rd_data[QDW + 3 * CW +: 16];

   // The cap is clamped to the queue depth.
   assign cap = (32'(max_ff) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(max_ff);

   assign use_best = (open_ff != '0) && (best_pend < cap);
   assign can_open = (open_ff != OW'(NUM_QUEUES));
   assign target   = use_best ? best_index : QIW'(open_ff);

   assign sel_q    = QIW'(req_ff.queue_select);
   assign sel_open = (32'(req_ff.queue_select) < 32'(open_ff));

   // A queue being opened has never been written and starts from zero.
   assign e_head = new_ff ? '0 : qs_head;
   assign e_pend = new_ff ? '0 : qs_pend;
   assign e_cpu  = new_ff ? '0 : qs_cpu;
   assign e_io   = new_ff ? '0 : qs_io;
   assign e_peak = new_ff ? '0 : qs_peak;

   assign sub_pend = e_pend + CW'(1);
   assign sub_cpu  = (req_ff.request_kind == KIND_CPU) ? e_cpu + CW'(1) : e_cpu;
   assign sub_io   = (req_ff.request_kind == KIND_IO) ? e_io + CW'(1) : e_io;
   assign sub_peak = (req_ff.request_kind == KIND_IO && req_ff.cycle_count > e_peak) ?
                     req_ff.cycle_count : e_peak;

   // Tail slot is head plus pending, which stays below twice the depth.
   assign slot_sum  = (CW + 1)'(e_head) + (CW + 1)'(e_pend);
   assign slot_wrap = (slot_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                      slot_sum - (CW + 1)'(QUEUE_DEPTH) : slot_sum;

   assign pop_kind  = st_rd_data[STORE_W-1 -: 2];
   assign head_next = (QDW + 1)'(head_ff) + (QDW + 1)'(1);
   assign pop_head  = (head_next == (QDW + 1)'(QUEUE_DEPTH)) ? '0 : QDW'(head_next);
   assign pop_pend  = pend_ff - CW'(1);
   assign pop_cpu   = (pop_kind == KIND_CPU && cpu_ff != '0) ? cpu_ff - CW'(1) : cpu_ff;
   assign pop_io    = (pop_kind == KIND_IO && io_ff != '0) ? io_ff - CW'(1) : io_ff;

   // RAM addressing.
   always_comb begin
      qs_rd_en   = 1'b0;
      qs_rd_addr = sel_q;
      case (state_ff)
         S_SCAN: begin
            qs_rd_en   = 1'b1;
            qs_rd_addr = cnt_ff;
         end
         S_DECIDE: begin
            qs_rd_en   = 1'b1;
            qs_rd_addr = target;
         end
         S_RM_CHECK: begin
            qs_rd_en = 1'b1;
         end
         default: begin
            qs_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      qs_wr_en   = 1'b0;
      qs_wr_addr = target_ff;
      qs_wr_data = {sub_peak, sub_io, sub_cpu, sub_pend, QDW'(e_head)};
      if (state_ff == S_SUB_UPD) begin
         qs_wr_en = 1'b1;
      end else if (state_ff == S_RM_POP) begin
         qs_wr_en   = 1'b1;
         qs_wr_addr = sel_q;
         qs_wr_data = {peak_ff, pop_io, pop_cpu, pop_pend, pop_head};
      end
   end

   assign st_rd_en   = (state_ff == S_RM_HEAD);
   assign st_rd_addr = SAW'(sel_q) * SAW'(QUEUE_DEPTH) + SAW'(qs_head);
   assign st_wr_en   = (state_ff == S_SUB_UPD);
   assign st_wr_addr = SAW'(target_ff) * SAW'(QUEUE_DEPTH) + SAW'(slot_wrap);
   assign st_wr_data = {req_ff.request_kind, req_ff.cycle_count, req_ff.request_id};

   assign scan_ctrl.clear = accept;
   assign scan_ctrl.issue = (state_ff == S_SCAN);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      max_in        = csr_wr_en ? csr_wr_data : max_ff;
      open_in       = open_ff;
      cnt_in        = cnt_ff;
      target_in     = target_ff;
      new_in        = new_ff;
      cmd_in        = cmd_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      pend_in       = pend_ff;
      cpu_in        = cpu_ff;
      io_in         = io_ff;
      peak_in       = peak_ff;
      res_status_in = res_status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_tuser;
               req_in        = req_tdata;
               cnt_in        = '0;
               res_status_in = ST_OK;
               res_in        = '0;
               case (req_tuser)
                  CMD_SUBMIT: begin
                     state_in = (open_ff == '0) ? S_DECIDE : S_SCAN;
                  end
                  CMD_STATS: begin
                     state_in = (open_ff == '0) ? S_REPORT : S_SCAN;
                  end
                  CMD_REMOVE: begin
                     state_in = S_RM_CHECK;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = QIW'(cnt_ff + QIW'(1));
            if (cnt_ff == QIW'(open_ff - OW'(1))) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = (cmd_ff == CMD_SUBMIT) ? S_DECIDE : S_REPORT;
         end
         S_DECIDE: begin
            if (use_best || can_open) begin
               target_in = target;
               new_in    = !use_best;
               state_in  = S_SUB_UPD;
            end else begin
               // Every queue is open and at its cap: the request is dropped.
               res_status_in       = ST_FULL;
               res_in.queue_index   = 4'(best_index);
               res_in.queue_pending = 5'(best_pend);
               state_in             = S_FINISH;
            end
         end
         S_SUB_UPD: begin
            if (new_ff) begin
               open_in = open_ff + OW'(1);
            end
            res_in.queue_index   = 4'(target_ff);
            res_in.queue_pending = 5'(sub_pend);
            state_in             = S_FINISH;
         end
         S_RM_CHECK: begin
            res_in.queue_index = req_ff.queue_select;
            if (sel_open) begin
               state_in = S_RM_HEAD;
            end else begin
               res_status_in = ST_CLOSED;
               state_in      = S_FINISH;
            end
         end
         S_RM_HEAD: begin
            head_in = qs_head;
            pend_in = qs_pend;
            cpu_in  = qs_cpu;
            io_in   = qs_io;
            peak_in = qs_peak;
            if (qs_pend == '0) begin
               res_status_in = ST_EMPTY;
               state_in      = S_FINISH;
            end else begin
               state_in = S_RM_POP;
            end
         end
         S_RM_POP: begin
            res_in.out_request_id   = st_rd_data[30:0];
            res_in.out_cycle_count  = st_rd_data[46:31];
            res_in.out_request_kind = pop_kind;
            res_in.queue_pending    = 5'(pop_pend);
            state_in                = S_FINISH;
         end
         S_REPORT: begin
            res_in.cpu_found     = cpu_found;
            res_in.top_cpu_queue = 4'(cpu_index);
            res_in.top_cpu_count = 5'(cpu_max);
            res_in.io_found      = io_found;
            res_in.top_io_queue  = 4'(io_index);
            res_in.top_io_cycles = io_max;
            state_in             = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_ff       <= MAX_PER_QUEUE_RESET;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      target_ff     <= target_in;
      new_ff        <= new_in;
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      head_ff       <= head_in;
      pend_ff       <= pend_in;
      cpu_ff        <= cpu_in;
      io_ff         <= io_in;
      peak_ff       <= peak_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   sqd_ram #(
      .WIDTH(QS_W),
      .DEPTH(NUM_QUEUES)
   ) u_queue_state (
      .clock  (clock),
      .wr_en  (qs_wr_en),
      .wr_addr(qs_wr_addr),
      .wr_data(qs_wr_data),
      .rd_en  (qs_rd_en),
      .rd_addr(qs_rd_addr),
      .rd_data(qs_rd_data)
   );

   sqd_ram #(
      .WIDTH(STORE_W),
      .DEPTH(SD)
   ) u_request_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_en  (st_rd_en),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data)
   );

   sqd_scan #(
      .QIW(QIW),
      .CW (CW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .issue_index(cnt_ff),
      .entry_pend (qs_pend),
      .entry_cpu  (qs_cpu),
      .entry_peak (qs_peak),
      .best_index (best_index),
      .best_pend  (best_pend),
      .cpu_found  (cpu_found),
      .cpu_index  (cpu_index),
      .cpu_max    (cpu_max),
      .io_found   (io_found),
      .io_index   (io_index),
      .io_max     (io_max)
   );

   // The open count never passes the number of queues.
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OW'(NUM_QUEUES))
      else $error("open queue count above number of queues");

   // Queues are never closed again.
   a_open_grows: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> open_ff >= $past(open_ff))
      else $error("open queue count decreased");

   // A scan only runs over a nonempty set of open queues.
   a_scan_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (open_ff != '0))
      else $error("queue scan with no open queue");

   // A queue never records more pending requests than it has slots.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      qs_wr_en |-> (qs_wr_data[QDW +: CW] <= CW'(QUEUE_DEPTH)))
      else $error("queue pending count above queue depth");

endmodule
